### hdl/sps_pkg.sv
// Package for the segmented prime sieve: widths, limits and shared-unit codes.
package sps_pkg;

    localparam int unsigned LIM_W     = 13;   // limit, low bound, squares
    localparam int unsigned VAL_W     = 12;   // reported prime value
    localparam int unsigned SEG_W     = 7;    // segment number
    localparam int unsigned SMALL_W   = 7;    // small values: n, p, offsets
    localparam int unsigned CNT_W     = 5;    // small prime count
    localparam int unsigned MARK_N    = 65;   // strike bits, positions 0..64
    localparam int unsigned MAX_SP    = 18;   // kept small primes / results

    localparam logic [LIM_W-1:0] LIM_RESET = 13'd100;
    localparam logic [LIM_W-1:0] LIM_MIN   = 13'd4;
    localparam logic [LIM_W-1:0] LIM_MAX   = 13'd4096;

    localparam logic [CNT_W-1:0] SP_LAST   = 5'(MAX_SP - 1);
    localparam logic [CNT_W-1:0] SP_FULL   = 5'(MAX_SP);

    // operation of the shared adder/subtractor
    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

### hdl/sps_alu.sv
// Shared 13-bit adder/subtractor with borrow flag, used by the arithmetic sieve steps.
module sps_alu (
    input  sps_pkg::t_alu_op               i_op,
    input  logic [sps_pkg::LIM_W-1:0]      i_a,
    input  logic [sps_pkg::LIM_W-1:0]      i_b,
    output logic [sps_pkg::LIM_W-1:0]      o_y,
    output logic                           o_borrow
);

    logic [sps_pkg::LIM_W:0] w_sum;

    always_comb begin
        if (i_op == sps_pkg::ALU_SUB) begin
            w_sum = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_y      = w_sum[sps_pkg::LIM_W-1:0];
    // borrow only means something on a subtract: a < b
    assign o_borrow = (i_op == sps_pkg::ALU_SUB) && w_sum[sps_pkg::LIM_W];

endmodule

### hdl/segmented_prime_sieve_core.sv
// Segmented sieve of Eratosthenes core: one request per segment, primes out as word strobes.
// Sequence: a request after a limit write first rebuilds n and the small primes.
// Segment 0 then gives one word per list read; segment k computes its low bound and width,
//   reads, divides and strikes for each small prime, and scans up to 64 marks for primes.
// Throughput: one request at a time on the shared adder, busy high until the last word; no stalls.
// Reset (synchronous, active low) loads the limit 100 and marks the small primes stale.
module segmented_prime_sieve_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [6:0]  i_segment_number,
    // results, one word per strobe, cannot be stalled
    output logic        o_valid,
    output logic [11:0] o_prime_value,
    output logic        o_last_of_segment,
    output logic        o_segment_empty,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // sequencer states, one-hot
    typedef enum logic [17:0] {
        S_IDLE      = 18'b000000000000000001,
        S_SQ_TEST   = 18'b000000000000000010, // sq < target ?
        S_SQ_INC    = 18'b000000000000000100, // sq += 2r+1, r++
        S_SS_INIT   = 18'b000000000000001000, // next striking base i
        S_SS_STRIKE = 18'b000000000000010000, // strike multiples of i
        S_SS_SCAN   = 18'b000000000000100000, // collect small primes
        S_DISP      = 18'b000000000001000000,
        S_L_RD      = 18'b000000000010000000, // list read wait
        S_L_EMIT    = 18'b000000000100000000, // segment 0 output
        S_MUL       = 18'b000000001000000000, // low = seg * n, shift-add
        S_CMP       = 18'b000000010000000000, // low < limit ?
        S_WID       = 18'b000000100000000000, // segment width
        S_P_RD      = 18'b000001000000000000, // fetch small prime
        S_DIV       = 18'b000010000000000000, // low mod p, restoring
        S_OFF       = 18'b000100000000000000, // first offset to strike
        S_STRIKE    = 18'b001000000000000000,
        S_SCAN      = 18'b010000000000000000, // walk marks, pending word
        S_FIN       = 18'b100000000000000000  // last or empty word
    } t_state;

    t_state r_state;

    // register and control
    logic [sps_pkg::LIM_W-1:0]   r_cfg_lim;
    logic                        r_dirty;     // small primes must be rebuilt
    logic                        r_phase;     // 0: sqrt of limit, 1: sqrt of n
    logic [sps_pkg::CNT_W-1:0]   r_cnt;       // small prime count
    logic                        r_pend_v;
    logic                        r_ov;

    // datapath
    logic [sps_pkg::SEG_W-1:0]   r_seg;
    logic [sps_pkg::SMALL_W-1:0] r_r;
    logic [sps_pkg::LIM_W-1:0]   r_sq;
    logic [sps_pkg::LIM_W-1:0]   r_tgt;
    logic [sps_pkg::SMALL_W-1:0] r_n;
    logic [3:0]                  r_rs;        // ceil sqrt of n, at most 8
    logic [3:0]                  r_i;
    logic [sps_pkg::SMALL_W-1:0] r_c;
    logic [sps_pkg::MARK_N-1:0]  r_marks;
    logic [sps_pkg::SMALL_W-1:0] r_list [sps_pkg::MAX_SP];
    logic [sps_pkg::SMALL_W-1:0] r_prd;
    logic [sps_pkg::SMALL_W-1:0] r_j;
    logic [sps_pkg::CNT_W-1:0]   r_k;
    logic [sps_pkg::LIM_W-1:0]   r_low;
    logic [3:0]                  r_b;
    logic [sps_pkg::SMALL_W-1:0] r_rem;
    logic [sps_pkg::SMALL_W-1:0] r_w;
    logic [sps_pkg::SMALL_W-1:0] r_off;
    logic [sps_pkg::VAL_W-1:0]   r_pend;
    logic [sps_pkg::CNT_W-1:0]   r_found;
    logic [sps_pkg::VAL_W-1:0]   r_oval;
    logic                        r_olast;
    logic                        r_oempty;

    logic [sps_pkg::LIM_W-1:0]   w_lim;       // clamped limit
    logic                        w_cfg_wr;
    logic                        w_accept;

    // shared unit
    sps_pkg::t_alu_op            w_op;
    logic [sps_pkg::LIM_W-1:0]   w_a;
    logic [sps_pkg::LIM_W-1:0]   w_b;
    logic [sps_pkg::LIM_W-1:0]   w_y;
    logic                        w_borrow;

    logic [7:0]                  w_shift;     // remainder shifted with next bit
    logic                        w_hit;       // unmarked in scan
    logic                        w_scan_end;
    logic                        w_k_last;

    assign pready   = 1'b1;
    assign prdata   = {19'd0, r_cfg_lim};
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign o_valid           = r_ov;
    assign o_prime_value     = r_oval;
    assign o_last_of_segment = r_olast;
    assign o_segment_empty   = r_oempty;

    always_comb begin
        if (r_cfg_lim < sps_pkg::LIM_MIN) begin
            w_lim = sps_pkg::LIM_MIN;
        end else if (r_cfg_lim > sps_pkg::LIM_MAX) begin
            w_lim = sps_pkg::LIM_MAX;
        end else begin
            w_lim = r_cfg_lim;
        end
    end

    assign w_shift    = {r_rem, r_low[r_b]};
    assign w_hit      = !r_marks[r_j];
    assign w_scan_end = (r_j == r_w - 7'd1) || (w_hit && r_found == sps_pkg::SP_LAST);
    assign w_k_last   = (r_k == r_cnt - 5'd1);

    // operand routing into the shared adder
    always_comb begin
        w_op = sps_pkg::ALU_ADD;
        w_a  = '0;
        w_b  = '0;
        case (r_state)
            S_SQ_TEST: begin
                w_op = sps_pkg::ALU_SUB;
                w_a  = r_sq;
                w_b  = r_tgt;
            end
            S_SQ_INC: begin
                w_a = r_sq;
                w_b = {5'd0, r_r, 1'b1};
            end
            S_SS_INIT: begin
                w_a = {9'd0, r_i};
                w_b = {9'd0, r_i};
            end
            S_SS_STRIKE: begin
                w_a = {6'd0, r_c};
                w_b = {9'd0, r_i};
            end
            S_MUL: begin
                w_a = {r_low[11:0], 1'b0};
                w_b = r_seg[r_b[2:0]] ? {6'd0, r_n} : '0;
            end
            S_CMP: begin
                w_op = sps_pkg::ALU_SUB;
                w_a  = r_low;
                w_b  = w_lim;
            end
            S_WID: begin
                w_op = sps_pkg::ALU_SUB;
                w_a  = w_lim;
                w_b  = r_low;
            end
            S_DIV: begin
                w_op = sps_pkg::ALU_SUB;
                w_a  = {5'd0, w_shift};
                w_b  = {6'd0, r_prd};
            end
            S_OFF: begin
                w_op = sps_pkg::ALU_SUB;
                w_a  = {6'd0, r_prd};
                w_b  = {6'd0, r_rem};
            end
            S_STRIKE: begin
                w_a = {6'd0, r_off};
                w_b = {6'd0, r_prd};
            end
            S_SCAN: begin
                w_a = r_low;
                w_b = {6'd0, r_j};
            end
            default: begin
                w_op = sps_pkg::ALU_ADD;
            end
        endcase
    end

    sps_alu u_alu (
        .i_op     (w_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_y      (w_y),
        .o_borrow (w_borrow)
    );

    // control: state, register, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_lim <= sps_pkg::LIM_RESET;
            r_dirty   <= 1'b1;
            r_phase   <= 1'b0;
            r_cnt     <= '0;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            if (w_cfg_wr) begin
                r_cfg_lim <= pwdata[sps_pkg::LIM_W-1:0];
                r_dirty   <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase <= 1'b0;
                        r_state <= r_dirty ? S_SQ_TEST : S_DISP;
                    end
                end
                S_SQ_TEST: begin
                    if (w_borrow) begin
                        r_state <= S_SQ_INC;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_state <= S_SS_INIT;
                    end
                end
                S_SQ_INC: begin
                    r_state <= S_SQ_TEST;
                end
                S_SS_INIT: begin
                    if (r_i > r_rs) begin
                        r_cnt   <= '0;
                        r_state <= S_SS_SCAN;
                    end else begin
                        r_state <= S_SS_STRIKE;
                    end
                end
                S_SS_STRIKE: begin
                    if (r_c > r_n) begin
                        r_state <= S_SS_INIT;
                    end
                end
                S_SS_SCAN: begin
                    if (!r_marks[r_j] && r_cnt < sps_pkg::SP_FULL) begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                    if (r_j == r_n) begin
                        r_dirty <= 1'b0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_pend_v <= 1'b0;
                    r_state  <= (r_seg == '0) ? S_L_RD : S_MUL;
                end
                S_L_RD: begin
                    r_state <= S_L_EMIT;
                end
                S_L_EMIT: begin
                    r_ov    <= 1'b1;
                    r_state <= w_k_last ? S_IDLE : S_L_RD;
                end
                S_MUL: begin
                    if (r_b == 4'd0) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= w_borrow ? S_WID : S_FIN;
                end
                S_WID: begin
                    r_state <= S_P_RD;
                end
                S_P_RD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_b == 4'd0) begin
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_state <= S_STRIKE;
                end
                S_STRIKE: begin
                    if (r_off >= r_w) begin
                        r_state <= w_k_last ? S_SCAN : S_P_RD;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_pend_v <= 1'b1;
                        r_ov     <= r_pend_v;
                    end
                    if (w_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prd <= r_list[r_k];
        case (r_state)
            S_IDLE: begin
                r_seg <= i_segment_number;
                r_r   <= '0;
                r_sq  <= '0;
                r_tgt <= w_lim;
            end
            S_SQ_TEST: begin
                if (!w_borrow) begin
                    if (!r_phase) begin
                        r_n   <= r_r;
                        r_tgt <= {6'd0, r_r};
                        r_r   <= '0;
                        r_sq  <= '0;
                    end else begin
                        r_rs    <= r_r[3:0];
                        r_marks <= '0;
                        r_i     <= 4'd2;
                    end
                end
            end
            S_SQ_INC: begin
                r_sq <= w_y;
                r_r  <= r_r + 7'd1;
            end
            S_SS_INIT: begin
                r_c <= w_y[sps_pkg::SMALL_W-1:0];
                r_j <= 7'd2;
            end
            S_SS_STRIKE: begin
                if (r_c > r_n) begin
                    r_i <= r_i + 4'd1;
                end else begin
                    r_marks[r_c] <= 1'b1;
                    r_c          <= w_y[sps_pkg::SMALL_W-1:0];
                end
            end
            S_SS_SCAN: begin
                if (!r_marks[r_j] && r_cnt < sps_pkg::SP_FULL) begin
                    r_list[r_cnt] <= r_j;
                end
                r_j <= r_j + 7'd1;
            end
            S_DISP: begin
                r_k   <= '0;
                r_low <= '0;
                r_b   <= 4'(sps_pkg::SEG_W - 1);
            end
            S_L_EMIT: begin
                r_oval   <= {5'd0, r_prd};
                r_olast  <= w_k_last;
                r_oempty <= 1'b0;
                r_k      <= r_k + 5'd1;
            end
            S_MUL: begin
                r_low <= w_y;
                r_b   <= r_b - 4'd1;
            end
            S_WID: begin
                // width = min(n, limit - low)
                r_w     <= (w_y < {6'd0, r_n}) ? w_y[sps_pkg::SMALL_W-1:0] : r_n;
                r_marks <= '0;
            end
            S_P_RD: begin
                r_rem <= '0;
                r_b   <= 4'(sps_pkg::VAL_W - 1);
            end
            S_DIV: begin
                r_rem <= w_borrow ? w_shift[sps_pkg::SMALL_W-1:0]
                                  : w_y[sps_pkg::SMALL_W-1:0];
                r_b   <= r_b - 4'd1;
            end
            S_OFF: begin
                r_off <= (r_rem == '0) ? '0 : w_y[sps_pkg::SMALL_W-1:0];
            end
            S_STRIKE: begin
                if (r_off < r_w) begin
                    r_marks[r_off] <= 1'b1;
                    r_off          <= w_y[sps_pkg::SMALL_W-1:0];
                end else begin
                    r_k     <= r_k + 5'd1;
                    r_j     <= '0;
                    r_found <= '0;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    // previous prime goes out, this one waits to learn if it is last
                    r_oval   <= r_pend;
                    r_olast  <= 1'b0;
                    r_oempty <= 1'b0;
                    r_pend   <= w_y[sps_pkg::VAL_W-1:0];
                    r_found  <= r_found + 5'd1;
                end
                r_j <= r_j + 7'd1;
            end
            S_FIN: begin
                r_oval   <= r_pend_v ? r_pend : '0;
                r_olast  <= 1'b1;
                r_oempty <= !r_pend_v;
            end
            default: begin
                r_b <= r_b;
            end
        endcase
    end

endmodule

### dv/tb_segmented_prime_sieve_core.sv
// Self-checking testbench for segmented_prime_sieve_core: segment requests and limit writes.
module tb_segmented_prime_sieve_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  REG_LIMIT_ADDR  = 3'd0;   // upper_limit
    localparam logic [2:0]  REG_UNUSED_ADDR = 3'd4;   // no register here
    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned SETTLE_CYCLES   = 600;    // idle wait after the final drain
    localparam int unsigned CHUNKS          = 9;
    localparam int unsigned CHUNK_ITEMS     = 41;

    // one prime word as the block reports it
    typedef struct packed {
        logic [sps_pkg::VAL_W-1:0] prime;
        logic                      last;
        logic                      empty;
    } t_prime_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [sps_pkg::SEG_W-1:0]  i_segment_number = '0;
    logic                       o_valid;
    logic [sps_pkg::VAL_W-1:0]  o_prime_value;
    logic                       o_last_of_segment;
    logic                       o_segment_empty;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [2:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // segments waiting to be requested, prime words waiting to come back
    logic [sps_pkg::SEG_W-1:0]  segments_pending[$];
    t_prime_word                prime_words_due[$];

    // our copy of the limit register, raw 13 bits as written
    logic [sps_pkg::LIM_W-1:0]  limit_shadow = sps_pkg::LIM_RESET;
    int unsigned                send_idle_pct = 0;

    int unsigned       errors = 0;
    int unsigned       segments_sent = 0;
    int unsigned       words_checked = 0;
    int unsigned       empty_words = 0;
    int unsigned       limit_writes = 0;
    int unsigned       cycle_count = 0;

    segmented_prime_sieve_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_segment_number  (i_segment_number),
        .o_valid           (o_valid),
        .o_prime_value     (o_prime_value),
        .o_last_of_segment (o_last_of_segment),
        .o_segment_empty   (o_segment_empty),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sieve predictor
    // ------------------------------------------------------------------

    // out-of-range limits saturate to 4 / 4096 (4096 is also 64 squared)
    function automatic int unsigned clamp_limit(input logic [sps_pkg::LIM_W-1:0] raw);
        int unsigned lim;
        lim = raw;
        if (lim < sps_pkg::LIM_MIN) lim = sps_pkg::LIM_MIN;
        if (lim > sps_pkg::LIM_MAX) lim = sps_pkg::LIM_MAX;
        return lim;
    endfunction

    // segment width: smallest w with w*w >= lim
    function automatic int unsigned seg_width(input int unsigned lim);
        int unsigned w;
        w = 0;
        while (w * w < lim) w++;
        return w;
    endfunction

    // Expected words for one segment request, appended to prime_words_due.
    // Small primes are rebuilt from the limit on every request.
    function automatic void sieve_segment(input logic [sps_pkg::LIM_W-1:0] lim_raw,
                                          input logic [sps_pkg::SEG_W-1:0] seg);
        int unsigned lim, n, r, low, high, i, c, p;
        int unsigned base_primes[$];
        bit          struck[sps_pkg::MARK_N];
        t_prime_word words[$];
        t_prime_word w;

        lim = clamp_limit(lim_raw);
        n   = seg_width(lim);
        r   = seg_width(n);

        // plain sieve over 2..n
        foreach (struck[k]) struck[k] = 1'b0;
        for (i = 2; i <= r; i++)
            for (c = 2 * i; c <= n; c += i)
                struck[c] = 1'b1;
        for (i = 2; i <= n; i++)
            if (!struck[i] && base_primes.size() < sps_pkg::MAX_SP)
                base_primes = {base_primes, i};

        if (seg == 0) begin
            foreach (base_primes[k]) begin
                if (words.size() < sps_pkg::MAX_SP) begin
                    w = '{prime: (sps_pkg::VAL_W)'(base_primes[k]), last: 1'b0, empty: 1'b0};
                    words = {words, w};
                end
            end
        end else begin
            low = seg * n;
            if (low < lim) begin
                high = low + n;
                if (high > lim) high = lim;
                foreach (struck[k]) struck[k] = 1'b0;
                // strike from ceil(low/p)*p; a prime equal to n is struck in segment 1
                foreach (base_primes[k]) begin
                    p = base_primes[k];
                    for (c = ((low + p - 1) / p) * p; c < high; c += p)
                        struck[c - low] = 1'b1;
                end
                for (c = low; c < high && words.size() < sps_pkg::MAX_SP; c++) begin
                    if (!struck[c - low]) begin
                        w = '{prime: (sps_pkg::VAL_W)'(c), last: 1'b0, empty: 1'b0};
                        words = {words, w};
                    end
                end
            end
        end

        // no primes, or segment past the limit: one empty word
        if (words.size() == 0) begin
            w = '{prime: '0, last: 1'b1, empty: 1'b1};
            words = {words, w};
        end else begin
            words[words.size() - 1].last = 1'b1;
        end
        foreach (words[k]) prime_words_due = {prime_words_due, words[k]};
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pops the pending queue, holds start until busy is low.
    // One nonblocking update per signal per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        logic                      nxt_start;
        logic [sps_pkg::SEG_W-1:0] nxt_seg;
        if (!i_rst_n) begin
            start            <= 1'b0;
            i_segment_number <= '0;
        end else begin
            nxt_start = start;
            nxt_seg   = i_segment_number;
            // word accepted at this edge: predict its primes
            if (start && !busy) begin
                sieve_segment(limit_shadow, i_segment_number);
                segments_sent++;
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (segments_pending.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt_start = 1'b1;
                    nxt_seg   = segments_pending.pop_front();
                end else begin
                    // junk on the segment port while idle; must be ignored
                    nxt_seg = (sps_pkg::SEG_W)'($urandom);
                end
            end
            start            <= nxt_start;
            i_segment_number <= nxt_seg;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every strobed word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_proc
        t_prime_word want;
        if (i_rst_n && o_valid) begin
            if (prime_words_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual prime=%0d last=%0b empty=%0b",
                         $realtime, o_prime_value, o_last_of_segment, o_segment_empty);
                errors++;
            end else begin
                want = prime_words_due.pop_front();
                words_checked++;
                if (o_segment_empty) empty_words++;
                if (o_prime_value !== want.prime || o_last_of_segment !== want.last ||
                    o_segment_empty !== want.empty) begin
                    $display({"%0t: mismatch: expected prime=%0d last=%0b empty=%0b,",
                              " actual prime=%0d last=%0b empty=%0b"},
                             $realtime, want.prime, want.last, want.empty,
                             o_prime_value, o_last_of_segment, o_segment_empty);
                    errors++;
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still due", $realtime, prime_words_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access until pready
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_LIMIT_ADDR) begin
            limit_shadow = data[sps_pkg::LIM_W-1:0];
            limit_writes++;
        end
        @(negedge i_clk);
    endtask

    // limit write, upper data bits sometimes filled with junk
    task automatic write_limit(input logic [sps_pkg::LIM_W-1:0] lim);
        logic [31-sps_pkg::LIM_W:0] junk;
        junk = $urandom_range(0, 1) ? (32 - sps_pkg::LIM_W)'($urandom) : '0;
        apb_write(REG_LIMIT_ADDR, {junk, lim});
    endtask

    // sender pause: everything requested and every word back, block idle
    task automatic wait_drained();
        @(negedge i_clk);
        while (segments_pending.size() != 0 || start || prime_words_due.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    initial begin : stim_proc
        int unsigned               lim_eff, n, last_seg, pick, chunk, k;
        logic [sps_pkg::LIM_W-1:0] lim_raw;
        logic [sps_pkg::SEG_W-1:0] seg;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part, sender never idles ---
        send_idle_pct = 0;

        // reset limit 100 (n = 10): small primes, first, last, past end, top seg number
        segments_pending = '{7'd0, 7'd1, 7'd9, 7'd10, 7'd127};
        wait_drained();

        // n = 7 is prime: listed in segment 0, struck in segment 1
        write_limit(13'd49);
        segments_pending = '{7'd0, 7'd1, 7'd6, 7'd7};
        wait_drained();

        // partial last segment [90,91) has no prime
        write_limit(13'd91);
        segments_pending = '{7'd9, 7'd0};
        wait_drained();

        // limit below range saturates to 4 (n = 2)
        write_limit(13'd0);
        segments_pending = '{7'd0, 7'd1, 7'd2};
        wait_drained();

        // limit above range saturates to 4096 (n = 64, full 18-prime list)
        write_limit(13'h1FFF);
        segments_pending = '{7'd0, 7'd63, 7'd64};
        wait_drained();

        // write to a non-existent register must leave the limit alone
        apb_write(REG_UNUSED_ADDR, 32'd13);
        segments_pending = '{7'd0};
        wait_drained();

        write_limit(13'd3);
        segments_pending = '{7'd1};
        wait_drained();

        // [48,50): 48 and 49 both struck -> empty word
        write_limit(13'd50);
        segments_pending = '{7'd6};
        wait_drained();

        // --- random part: three idle regimes, new limit per chunk ---
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            send_idle_pct = (chunk < 3) ? 19 : (chunk < 6) ? 54 : 0;
            wait_drained();

            pick = $urandom_range(0, 7);
            case (pick)
                0: begin
                    lim_raw = (sps_pkg::LIM_W)'($urandom_range(0, 3));
                end
                1: begin
                    lim_raw = (sps_pkg::LIM_W)'($urandom_range(4097, 8191));
                end
                2: begin
                    lim_raw = sps_pkg::LIM_MAX;
                end
                3: begin
                    lim_raw = sps_pkg::LIM_MIN;
                end
                default: begin
                    lim_raw = (sps_pkg::LIM_W)'($urandom_range(5, 4095));
                end
            endcase
            write_limit(lim_raw);

            lim_eff  = clamp_limit(lim_raw);
            n        = seg_width(lim_eff);
            last_seg = (lim_eff - 1) / n;

            for (k = 0; k < CHUNK_ITEMS; k++) begin
                // mostly real segments, some small-prime requests, some past the end
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    seg = (sps_pkg::SEG_W)'($urandom_range(0, 127));
                else if (pick == 1)
                    seg = (sps_pkg::SEG_W)'(last_seg + 1);
                else if (pick <= 4)
                    seg = '0;
                else
                    seg = (sps_pkg::SEG_W)'($urandom_range(1, last_seg));
                segments_pending = {segments_pending, seg};
                // occasional full drain mid-chunk
                if ($urandom_range(0, 29) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d segment requests over %0d limit writes, saturated and in range.",
                 segments_sent, limit_writes);
        $display("Checked %0d prime words, %0d of them empty-segment words.",
                 words_checked, empty_words);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/sps_pkg.sv
hdl/sps_alu.sv
hdl/segmented_prime_sieve_core.sv
dv/tb_segmented_prime_sieve_core.sv
